// File: sv/mlfq_pkg.sv
// ----------------------------------------------------------------------------
// mlfq_pkg
// Shared types and constants for the multilevel feedback queue scheduler core.
// ----------------------------------------------------------------------------
package mlfq_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_ARRIVE,
    ST_PICK,
    ST_RUN,
    ST_OUTPUT
  } state_t;

  // Configuration register indexes
  localparam logic [2:0] REG_LEVEL_COUNT = 3'd0;
  localparam logic [2:0] REG_QUANTUM0    = 3'd1;
  localparam logic [2:0] REG_QUANTUM1    = 3'd2;
  localparam logic [2:0] REG_QUANTUM2    = 3'd3;
  localparam logic [2:0] REG_QUANTUM3    = 3'd4;

  localparam logic [2:0]  LEVEL_COUNT_RESET = 3'd3;
  localparam logic [15:0] QUANTUM0_RESET    = 16'd2;
  localparam logic [15:0] QUANTUM1_RESET    = 16'd4;
  localparam logic [15:0] QUANTUM2_RESET    = 16'd8;
  localparam logic [15:0] QUANTUM3_RESET    = 16'd16;

  localparam int TW = 23;          // time width
  localparam int NUM_QUANTA = 4;
  localparam int OUT_DATA_W = 184;

endpackage

// File: sv/mlfq_schedule_simulator_core.sv
// ----------------------------------------------------------------------------
// mlfq_schedule_simulator_core
// Loads processes as (arrival, burst) pairs and simulates a multilevel
// feedback queue schedule, then streams per-process timing results.
// ----------------------------------------------------------------------------
// Usage: each input transaction on the s_axis side carries one process. It is
// kept in a table sorted by arrival (stable, ties keep load order). A load
// moves each entry with a later arrival up one slot, then writes the new
// entry into the gap. Loads beyond MAX_PROCS are dropped and flagged.
// The transaction with s_axis_tlast high starts the simulation: each arrival
// enters level 0 in an arrival check, each time slice runs as an arrival
// check, a queue pop, then execute and requeue, and an idle stretch is an
// arrival check and a clock jump to the next arrival. The run is paced by
// the single queue-slot memory port and the shared time adder.
// Results then leave on m_axis, one per process in arrival order, one per
// cycle while m_axis_tready is high; m_axis_tlast marks the final one.
// A stalled receiver holds the result register and the sequencer waits.
// s_axis_tready is low from an accepted item until its load or the whole
// run is finished. Reset clears the process set and loads the default
// configuration (3 levels, quanta 2, 4, 8, 16); configuration is kept
// across runs.
// ----------------------------------------------------------------------------
module mlfq_schedule_simulator_core
  import mlfq_pkg::*;
#(
  parameter int MAX_PROCS  = 16,
  parameter int MAX_LEVELS = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // arrival_time [15:0], burst_time [31:16]
  input  logic [31:0]           s_axis_tdata,
  input  logic                  s_axis_tlast,   // last_process
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // process_number [6:0], arrival_echo [22:7], burst_echo [38:23],
  // start_time [61:39], completion_time [84:62], turnaround_time [107:85],
  // waiting_time [130:108], response_time [153:131], idle_total [176:154],
  // dropped_flag [177], zero fill [183:178]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tlast,   // last_result
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [15:0]           cfg_data
);

  localparam int PW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CW = $clog2(MAX_PROCS + 1);
  localparam int LW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam logic [CW:0] MAXP = (CW+1)'(MAX_PROCS);
  localparam logic [3:0]  MAXL = 4'(MAX_LEVELS);

  // configuration
  logic [2:0]  level_count;
  logic [15:0] quanta [NUM_QUANTA];

  // process table
  logic [15:0]   arrival_store   [MAX_PROCS];
  logic [15:0]   burst_store     [MAX_PROCS];
  logic [PW-1:0] order_store     [MAX_PROCS];
  logic [15:0]   remaining_store [MAX_PROCS];
  logic [TW-1:0] start_store     [MAX_PROCS];
  logic [TW-1:0] finish_store    [MAX_PROCS];
  logic [MAX_PROCS-1:0] started_flags;

  logic [PW-1:0] queue_slots [MAX_LEVELS][MAX_PROCS];
  logic [PW-1:0] queue_heads  [MAX_LEVELS];
  logic [CW-1:0] queue_counts [MAX_LEVELS];

  logic [CW-1:0] loaded_count, next_arrival, done_count, pos, out_k;
  logic [TW-1:0] clock_now, idle_ticks;
  logic          overflow_seen;
  logic [15:0]   in_arrival, in_burst;
  logic          in_last;
  logic [PW-1:0] run_idx;
  logic [LW-1:0] run_lv;

  state_t state, state_next;

  // ---------------------------------------------------------------- helpers
  logic [3:0]    levels;
  logic [3:0]    lc_ext;
  logic          lv_found;
  logic [LW-1:0] lv_sel;
  logic [CW-1:0] pos_m1;
  logic          shift_more;
  logic          arr_ready;
  logic [15:0]   q_sel, ex;
  logic [15:0]   rem_cur, rem_new;
  logic [TW-1:0] clock_run;
  logic [LW-1:0] push_lv;
  logic [LW-1:0] push_lv_w;
  logic [PW-1:0] push_tail;
  logic [CW:0]   tail_sum;
  logic [PW-1:0] nai_idx, k_idx;
  logic          s_acc, out_load;

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] v);
    logic [CW:0] t;
    t = (CW+1)'(v) + 1'b1;
    if (t >= MAXP) t = '0;
    return t[PW-1:0];
  endfunction

  always_comb begin
    lc_ext = {1'b0, level_count};
    levels = (lc_ext == 4'd0) ? 4'd1 : lc_ext;
    if (levels > 4'd4) levels = 4'd4;
    if (levels > MAXL) levels = MAXL;
  end

  // Highest-priority non-empty level within the levels in use.
  always_comb begin
    lv_found = 1'b0;
    lv_sel   = '0;
    for (int l = MAX_LEVELS - 1; l >= 0; l--) begin
      if ((4'(l) < levels) && (queue_counts[l] != '0)) begin
        lv_found = 1'b1;
        lv_sel   = LW'(l);
      end
    end
  end

  assign pos_m1     = pos - 1'b1;
  assign shift_more = (pos != '0) && (arrival_store[pos_m1[PW-1:0]] > in_arrival);
  assign nai_idx    = next_arrival[PW-1:0];
  assign arr_ready  = (next_arrival < loaded_count) &&
                      ({7'd0, arrival_store[nai_idx]} <= clock_now);
  assign k_idx      = out_k[PW-1:0];

  always_comb begin
    q_sel = quanta[0];
    for (int l = 0; l < NUM_QUANTA; l++) begin
      if (4'(run_lv) == 4'(l)) q_sel = quanta[l];
    end
    if (q_sel == '0) q_sel = 16'd1;
  end

  assign rem_cur   = remaining_store[run_idx];
  assign ex        = (rem_cur < q_sel) ? rem_cur : q_sel;
  assign rem_new   = rem_cur - ex;
  assign clock_run = clock_now + TW'(ex);
  assign push_lv   = ((4'(run_lv) + 4'd1) < levels) ? LW'(4'(run_lv) + 4'd1) : run_lv;
  assign push_lv_w = (state == ST_RUN) ? push_lv : '0;

  always_comb begin
    tail_sum = (CW+1)'(queue_heads[push_lv_w]) + (CW+1)'(queue_counts[push_lv_w]);
    if (tail_sum >= MAXP) tail_sum = tail_sum - MAXP;
    push_tail = tail_sum[PW-1:0];
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state == ST_OUTPUT) && (!m_axis_tvalid || m_axis_tready);

  // ------------------------------------------------------------ next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_acc) begin
          if (loaded_count < CW'(MAX_PROCS)) state_next = ST_SHIFT;
          else if (s_axis_tlast) state_next = ST_ARRIVE;
        end
      end
      ST_SHIFT: begin
        if (!shift_more) state_next = in_last ? ST_ARRIVE : ST_IDLE;
      end
      ST_ARRIVE: begin
        if (done_count == loaded_count) state_next = ST_OUTPUT;
        else if (!arr_ready) state_next = ST_PICK;
      end
      ST_PICK: begin
        if (lv_found) state_next = ST_RUN;
        else if (next_arrival >= loaded_count) state_next = ST_OUTPUT;
        else state_next = ST_ARRIVE;
      end
      ST_RUN: state_next = ST_ARRIVE;
      ST_OUTPUT: begin
        if (out_load && (out_k + 1'b1 == loaded_count)) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // ------------------------------------------------------------ configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      level_count <= LEVEL_COUNT_RESET;
      quanta[0]   <= QUANTUM0_RESET;
      quanta[1]   <= QUANTUM1_RESET;
      quanta[2]   <= QUANTUM2_RESET;
      quanta[3]   <= QUANTUM3_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LEVEL_COUNT: level_count <= cfg_data[2:0];
        REG_QUANTUM0:    quanta[0]   <= cfg_data;
        REG_QUANTUM1:    quanta[1]   <= cfg_data;
        REG_QUANTUM2:    quanta[2]   <= cfg_data;
        REG_QUANTUM3:    quanta[3]   <= cfg_data;
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------ table stores
  always_ff @(posedge clk) begin
    if (s_acc) begin
      in_arrival <= s_axis_tdata[15:0];
      in_burst   <= s_axis_tdata[31:16];
      in_last    <= s_axis_tlast;
    end
    if (state == ST_SHIFT) begin
      if (shift_more) begin
        arrival_store[pos[PW-1:0]]   <= arrival_store[pos_m1[PW-1:0]];
        burst_store[pos[PW-1:0]]     <= burst_store[pos_m1[PW-1:0]];
        order_store[pos[PW-1:0]]     <= order_store[pos_m1[PW-1:0]];
        remaining_store[pos[PW-1:0]] <= remaining_store[pos_m1[PW-1:0]];
      end else begin
        arrival_store[pos[PW-1:0]]   <= in_arrival;
        burst_store[pos[PW-1:0]]     <= in_burst;
        order_store[pos[PW-1:0]]     <= loaded_count[PW-1:0];
        remaining_store[pos[PW-1:0]] <= in_burst;
      end
    end
    if (state == ST_RUN) begin
      remaining_store[run_idx] <= rem_new;
      if (!started_flags[run_idx]) start_store[run_idx] <= clock_now;
      if (rem_new == '0) finish_store[run_idx] <= clock_run;
      else queue_slots[push_lv][push_tail] <= run_idx;
    end
    if ((state == ST_ARRIVE) && (done_count != loaded_count) && arr_ready) begin
      queue_slots[0][push_tail] <= nai_idx;
    end
    if ((state == ST_PICK) && lv_found) begin
      run_idx <= queue_slots[lv_sel][queue_heads[lv_sel]];
      run_lv  <= lv_sel;
    end
  end

  // ------------------------------------------------------------ control state
  always_ff @(posedge clk) begin
    if (rst) begin
      loaded_count  <= '0;
      next_arrival  <= '0;
      done_count    <= '0;
      clock_now     <= '0;
      idle_ticks    <= '0;
      overflow_seen <= 1'b0;
      started_flags <= '0;
      pos           <= '0;
      out_k         <= '0;
      for (int l = 0; l < MAX_LEVELS; l++) begin
        queue_heads[l]  <= '0;
        queue_counts[l] <= '0;
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_acc) begin
            pos <= loaded_count;
            if (loaded_count >= CW'(MAX_PROCS)) overflow_seen <= 1'b1;
          end
        end
        ST_SHIFT: begin
          if (shift_more) pos <= pos_m1;
          else loaded_count <= loaded_count + 1'b1;
        end
        ST_ARRIVE: begin
          if ((done_count != loaded_count) && arr_ready) begin
            queue_counts[0] <= queue_counts[0] + 1'b1;
            next_arrival    <= next_arrival + 1'b1;
          end
        end
        ST_PICK: begin
          if (lv_found) begin
            queue_heads[lv_sel]  <= wrap_inc(queue_heads[lv_sel]);
            queue_counts[lv_sel] <= queue_counts[lv_sel] - 1'b1;
          end else if (next_arrival < loaded_count) begin
            idle_ticks <= idle_ticks + ({7'd0, arrival_store[nai_idx]} - clock_now);
            clock_now  <= {7'd0, arrival_store[nai_idx]};
          end
        end
        ST_RUN: begin
          started_flags[run_idx] <= 1'b1;
          clock_now <= clock_run;
          if (rem_new == '0) done_count <= done_count + 1'b1;
          else queue_counts[push_lv] <= queue_counts[push_lv] + 1'b1;
        end
        ST_OUTPUT: begin
          if (out_load) begin
            if (out_k + 1'b1 == loaded_count) begin
              // Last result is in the output register: clear the set.
              out_k         <= '0;
              loaded_count  <= '0;
              next_arrival  <= '0;
              done_count    <= '0;
              clock_now     <= '0;
              idle_ticks    <= '0;
              overflow_seen <= 1'b0;
              started_flags <= '0;
              for (int l = 0; l < MAX_LEVELS; l++) begin
                queue_heads[l]  <= '0;
                queue_counts[l] <= '0;
              end
            end else begin
              out_k <= out_k + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------ result register
  logic [TW-1:0] r_arr, r_st, r_ct, r_tat, r_wt, r_rsp;

  assign r_arr = {7'd0, arrival_store[k_idx]};
  assign r_st  = start_store[k_idx];
  assign r_ct  = finish_store[k_idx];
  assign r_tat = r_ct - r_arr;
  assign r_wt  = r_tat - {7'd0, burst_store[k_idx]};
  assign r_rsp = r_st - r_arr;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {6'd0, overflow_seen, idle_ticks, r_rsp, r_wt, r_tat, r_ct, r_st,
                       burst_store[k_idx], arrival_store[k_idx],
                       7'(order_store[k_idx]) + 7'd1};
      m_axis_tlast <= (out_k + 1'b1 == loaded_count);
    end
  end

endmodule
